/* rtl/cnv2d_pkg.sv */
// shared constants and types for the zero padded 2d convolution block
`timescale 1ns / 1ps

package cnv2d_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_KERNEL = 7;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 40;
  localparam int PROD_W  = 2 * VALUE_W;

  localparam int ROWS_W  = 7;
  localparam int COLS_W  = 7;
  localparam int KSIZE_W = 3;

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int KER_AW    = $clog2(KER_DEPTH);

  // signed tap coordinate, wide enough for row plus kernel offset
  localparam int IDX_W = COORD_W + KSIZE_W;

  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_KERNEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_IMAGE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST     = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_SIZE = 2'd2;

  typedef logic [CMD_W-1:0]          cmd_t;
  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

/* rtl/cnv2d_if.sv */
// valid/ready channel interfaces for request words and result words
`timescale 1ns / 1ps

interface cnv2d_item_if;
  logic              valid;
  logic              ready;
  cnv2d_pkg::cmd_t   cmd;
  cnv2d_pkg::coord_t row;
  cnv2d_pkg::coord_t col;
  cnv2d_pkg::value_t value;

  modport source (output valid, output cmd, output row, output col, output value,
                  input ready);
  modport sink (input valid, input cmd, input row, input col, input value,
                output ready);
endinterface

interface cnv2d_result_if;
  logic              valid;
  logic              ready;
  cnv2d_pkg::sum_t   sum;
  cnv2d_pkg::coord_t out_row;
  cnv2d_pkg::coord_t out_col;

  modport source (output valid, output sum, output out_row, output out_col,
                  input ready);
  modport sink (input valid, input sum, input out_row, input out_col,
                output ready);
endinterface

/* rtl/conv2d_zero_padded.sv */
// top level: zero padded 2d convolution with one shared multiply-accumulate
// loads (kernel or image word) leave the block idle; words are taken only in idle
// a request walks k*k kernel taps, one per cycle, through ram read, multiply, add
// then drain_a, drain_b, done; done loads the result once its register is free
// reset (synchronous, active high) clears control, sets rows=1, cols=1, kernel=3
// store contents are not cleared by reset and are undefined until loaded
`timescale 1ns / 1ps

module conv2d_zero_padded (
  input  logic                            clk,
  input  logic                            rst,
  cnv2d_item_if.sink                      item,
  cnv2d_result_if.source                  result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cnv2d_pkg::APB_AW-1:0]    paddr,
  input  logic [cnv2d_pkg::APB_DW-1:0]    pwdata,
  output logic [cnv2d_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_DONE
  } state_t;

  state_t state;

  logic [cnv2d_pkg::ROWS_W-1:0]  image_rows;
  logic [cnv2d_pkg::COLS_W-1:0]  image_cols;
  logic [cnv2d_pkg::KSIZE_W-1:0] kernel_size;

  logic [cnv2d_pkg::ROWS_W-1:0]  nr_eff;
  logic [cnv2d_pkg::COLS_W-1:0]  nc_eff;
  logic [cnv2d_pkg::KSIZE_W-1:0] k_eff;
  logic [cnv2d_pkg::KSIZE_W-1:0] kc;

  logic [cnv2d_pkg::KSIZE_W-1:0] tap_r;
  logic [cnv2d_pkg::KSIZE_W-1:0] tap_c;
  cnv2d_pkg::coord_t             req_row;
  cnv2d_pkg::coord_t             req_col;

  logic [cnv2d_pkg::IDX_W-1:0] ii;
  logic [cnv2d_pkg::IDX_W-1:0] jj;
  logic                        tap_ok;

  logic s1_v;
  logic p_v;
  logic signed [cnv2d_pkg::PROD_W-1:0] prod;
  cnv2d_pkg::sum_t acc;

  logic                        res_valid;
  cnv2d_pkg::sum_t             res_sum;
  cnv2d_pkg::coord_t           res_row;
  cnv2d_pkg::coord_t           res_col;

  logic accept;
  logic cfg_we;
  logic [cnv2d_pkg::REG_IDX_W-1:0] reg_idx;

  logic                               ker_we;
  logic [cnv2d_pkg::KER_AW-1:0]       ker_waddr;
  logic [cnv2d_pkg::KER_AW-1:0]       ker_raddr;
  logic [cnv2d_pkg::VALUE_W-1:0]      ker_q;
  logic                               img_we;
  logic [cnv2d_pkg::IMG_AW-1:0]       img_waddr;
  logic [cnv2d_pkg::IMG_AW-1:0]       img_raddr;
  logic [cnv2d_pkg::VALUE_W-1:0]      img_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[cnv2d_pkg::APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      cnv2d_pkg::REG_IMAGE_ROWS:  prdata = cnv2d_pkg::APB_DW'(image_rows);
      cnv2d_pkg::REG_IMAGE_COLS:  prdata = cnv2d_pkg::APB_DW'(image_cols);
      cnv2d_pkg::REG_KERNEL_SIZE: prdata = cnv2d_pkg::APB_DW'(kernel_size);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= cnv2d_pkg::ROWS_W'(1);
      image_cols  <= cnv2d_pkg::COLS_W'(1);
      kernel_size <= cnv2d_pkg::KSIZE_W'(3);
    end else if (cfg_we) begin
      unique case (reg_idx)
        cnv2d_pkg::REG_IMAGE_ROWS:  image_rows  <= pwdata[cnv2d_pkg::ROWS_W-1:0];
        cnv2d_pkg::REG_IMAGE_COLS:  image_cols  <= pwdata[cnv2d_pkg::COLS_W-1:0];
        cnv2d_pkg::REG_KERNEL_SIZE: kernel_size <= pwdata[cnv2d_pkg::KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to the supported sizes
  always_comb begin
    if (image_rows == '0) begin
      nr_eff = cnv2d_pkg::ROWS_W'(1);
    end else if (32'(image_rows) > cnv2d_pkg::MAX_ROWS) begin
      nr_eff = cnv2d_pkg::ROWS_W'(cnv2d_pkg::MAX_ROWS);
    end else begin
      nr_eff = image_rows;
    end
    if (image_cols == '0) begin
      nc_eff = cnv2d_pkg::COLS_W'(1);
    end else if (32'(image_cols) > cnv2d_pkg::MAX_COLS) begin
      nc_eff = cnv2d_pkg::COLS_W'(cnv2d_pkg::MAX_COLS);
    end else begin
      nc_eff = image_cols;
    end
    if (kernel_size == '0) begin
      k_eff = cnv2d_pkg::KSIZE_W'(1);
    end else if (32'(kernel_size) > cnv2d_pkg::MAX_KERNEL) begin
      k_eff = cnv2d_pkg::KSIZE_W'(cnv2d_pkg::MAX_KERNEL);
    end else begin
      k_eff = kernel_size;
    end
  end

  assign kc = k_eff >> 1;

  // image coordinate hit by the current tap
  assign ii = cnv2d_pkg::IDX_W'(req_row) + cnv2d_pkg::IDX_W'(tap_r) - cnv2d_pkg::IDX_W'(kc);
  assign jj = cnv2d_pkg::IDX_W'(req_col) + cnv2d_pkg::IDX_W'(tap_c) - cnv2d_pkg::IDX_W'(kc);
  assign tap_ok = !ii[cnv2d_pkg::IDX_W-1] && (ii < cnv2d_pkg::IDX_W'(nr_eff)) &&
                  !jj[cnv2d_pkg::IDX_W-1] && (jj < cnv2d_pkg::IDX_W'(nc_eff));

  assign ker_raddr = cnv2d_pkg::KER_AW'(tap_r) * cnv2d_pkg::KER_AW'(cnv2d_pkg::MAX_KERNEL) +
                     cnv2d_pkg::KER_AW'(tap_c);
  assign img_raddr = cnv2d_pkg::IMG_AW'(ii) * cnv2d_pkg::IMG_AW'(cnv2d_pkg::MAX_COLS) +
                     cnv2d_pkg::IMG_AW'(jj);

  // load words
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;

  assign ker_we = accept && (item.cmd == cnv2d_pkg::CMD_LOAD_KERNEL) &&
                  (32'(item.row) < cnv2d_pkg::MAX_KERNEL) &&
                  (32'(item.col) < cnv2d_pkg::MAX_KERNEL);
  assign img_we = accept && (item.cmd == cnv2d_pkg::CMD_LOAD_IMAGE) &&
                  (32'(item.row) < cnv2d_pkg::MAX_ROWS) &&
                  (32'(item.col) < cnv2d_pkg::MAX_COLS);
  assign ker_waddr = cnv2d_pkg::KER_AW'(item.row) * cnv2d_pkg::KER_AW'(cnv2d_pkg::MAX_KERNEL) +
                     cnv2d_pkg::KER_AW'(item.col);
  assign img_waddr = cnv2d_pkg::IMG_AW'(item.row) * cnv2d_pkg::IMG_AW'(cnv2d_pkg::MAX_COLS) +
                     cnv2d_pkg::IMG_AW'(item.col);

  cnv2d_ram #(
    .WIDTH (cnv2d_pkg::VALUE_W),
    .DEPTH (cnv2d_pkg::KER_DEPTH)
  ) u_kernel_ram (
    .clk   (clk),
    .we    (ker_we),
    .waddr (ker_waddr),
    .wdata (item.value),
    .raddr (ker_raddr),
    .rdata (ker_q)
  );

  cnv2d_ram #(
    .WIDTH (cnv2d_pkg::VALUE_W),
    .DEPTH (cnv2d_pkg::IMG_DEPTH)
  ) u_image_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (item.value),
    .raddr (img_raddr),
    .rdata (img_q)
  );

  // sequencer, mac pipeline and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_r     <= '0;
      tap_c     <= '0;
      s1_v      <= 1'b0;
      p_v       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_v <= (state == ST_RUN) && tap_ok;
      p_v  <= s1_v;
      prod <= $signed(ker_q) * $signed(img_q);
      if (p_v) begin
        acc <= acc + cnv2d_pkg::SUM_W'(prod);
      end
      if ((state == ST_DONE) && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && (item.cmd == cnv2d_pkg::CMD_REQUEST)) begin
            req_row <= item.row;
            req_col <= item.col;
            acc     <= '0;
            tap_r   <= '0;
            tap_c   <= '0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tap_c == k_eff - 1'b1) begin
            tap_c <= '0;
            if (tap_r == k_eff - 1'b1) begin
              state <= ST_DRAIN_A;
            end else begin
              tap_r <= tap_r + 1'b1;
            end
          end else begin
            tap_c <= tap_c + 1'b1;
          end
        end
        ST_DRAIN_A: state <= ST_DRAIN_B;
        ST_DRAIN_B: state <= ST_DONE;
        ST_DONE: begin
          if (!res_valid || result.ready) begin
            res_sum   <= acc;
            res_row   <= req_row;
            res_col   <= req_col;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid   = res_valid;
  assign result.sum     = res_sum;
  assign result.out_row = res_row;
  assign result.out_col = res_col;

  a_taps_in_kernel: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (tap_r < k_eff) && (tap_c < k_eff))
    else $error("tap counter beyond kernel size");

  a_pipe_empty_at_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !s1_v && !p_v)
    else $error("mac pipeline not drained at result");

  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && (!res_valid || result.ready) |=> result.valid && (state == ST_IDLE))
    else $error("finished request did not reach the result register");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) || (state == ST_DRAIN_A) || (state == ST_DRAIN_B) |-> !accept)
    else $error("word accepted during a request");

endmodule

/* rtl/cnv2d_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cnv2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/tb_conv2d_zero_padded.sv */
// testbench for the zero padded 2d convolution block: directed and random words against a predictor
`timescale 1ns / 1ps

module tb_conv2d_zero_padded;
  import cnv2d_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_CAP = 50;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    sum_t   sum;
    coord_t out_row;
    coord_t out_col;
  } pixel_exp_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  cnv2d_item_if   item_ch ();
  cnv2d_result_if res_ch ();

  conv2d_zero_padded u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch.sink),
    .result  (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // predictor state
  value_t img_mem [IMG_DEPTH];
  value_t ker_mem [KER_DEPTH];
  bit     img_written [IMG_DEPTH];
  bit     ker_written [KER_DEPTH];
  logic [ROWS_W-1:0]  rows_cfg;
  logic [COLS_W-1:0]  cols_cfg;
  logic [KSIZE_W-1:0] ksize_cfg;

  pixel_exp_t expected_pixels [$];

  int send_idle_pct;
  int recv_stall_pct;
  int errors = 0;
  int words_sent;
  int pixels_seen = 0;
  int reg_writes;
  int phases_run;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < PRINT_CAP)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int eff_rows();
    if (rows_cfg == 0) return 1;
    if (rows_cfg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_cfg);
  endfunction

  function automatic int eff_cols();
    if (cols_cfg == 0) return 1;
    if (cols_cfg > MAX_COLS) return MAX_COLS;
    return int'(cols_cfg);
  endfunction

  function automatic int eff_ksize();
    if (ksize_cfg == 0) return 1;
    return int'(ksize_cfg);
  endfunction

  function automatic sum_t conv_at(input int r, input int c);
    int nr;
    int nc;
    int k;
    int kc;
    int kr;
    int kcl;
    longint acc;
    nr  = eff_rows();
    nc  = eff_cols();
    k   = eff_ksize();
    kc  = k / 2;
    acc = 0;
    for (int ii = 0; ii < nr; ii++) begin
      kr = kc + ii - r;
      if (kr < 0 || kr >= k) continue;
      for (int jj = 0; jj < nc; jj++) begin
        kcl = kc + jj - c;
        if (kcl < 0 || kcl >= k) continue;
        acc += longint'(ker_mem[kr * MAX_KERNEL + kcl]) * longint'(img_mem[ii * MAX_COLS + jj]);
      end
    end
    return sum_t'(acc);
  endfunction

  function automatic void predict_word(input cmd_t c, input coord_t r, input coord_t cl,
                                       input value_t v);
    pixel_exp_t want;
    case (c)
      CMD_LOAD_KERNEL: begin
        if (r < MAX_KERNEL && cl < MAX_KERNEL) begin
          ker_mem[r * MAX_KERNEL + cl]     = v;
          ker_written[r * MAX_KERNEL + cl] = 1'b1;
        end
      end
      CMD_LOAD_IMAGE: begin
        img_mem[r * MAX_COLS + cl]     = v;
        img_written[r * MAX_COLS + cl] = 1'b1;
      end
      CMD_REQUEST: begin
        want.sum     = conv_at(r, cl);
        want.out_row = r;
        want.out_col = cl;
        expected_pixels.push_back(want);
      end
      default: ;
    endcase
  endfunction

  function automatic value_t rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return value_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // one word on the item channel, predicted at the edge where it is taken
  task automatic send_word(input cmd_t c, input coord_t r, input coord_t cl, input value_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd   <= c;
    item_ch.row   <= r;
    item_ch.col   <= cl;
    item_ch.value <= v;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_word(c, r, cl, v);
    words_sent++;
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IMAGE_ROWS:  rows_cfg  = data[ROWS_W-1:0];
      REG_IMAGE_COLS:  cols_cfg  = data[COLS_W-1:0];
      REG_KERNEL_SIZE: ksize_cfg = data[KSIZE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // junk in the upper bits must be dropped by the register
  task automatic apply_setting(input int rows_raw, input int cols_raw, input int k_raw);
    logic [APB_DW-1:0] data;
    data = $urandom();
    data[ROWS_W-1:0] = ROWS_W'(rows_raw);
    write_reg(REG_IMAGE_ROWS, data);
    data = $urandom();
    data[COLS_W-1:0] = COLS_W'(cols_raw);
    write_reg(REG_IMAGE_COLS, data);
    data = $urandom();
    data[KSIZE_W-1:0] = KSIZE_W'(k_raw);
    write_reg(REG_KERNEL_SIZE, data);
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default:       begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  // every entry a request can read must hold a loaded value
  task automatic fill_stores();
    int k;
    k = eff_ksize();
    for (int r = 0; r < k; r++)
      for (int c = 0; c < k; c++)
        if (!ker_written[r * MAX_KERNEL + c])
          send_word(CMD_LOAD_KERNEL, coord_t'(r), coord_t'(c), rand_value());
    for (int r = 0; r < eff_rows(); r++)
      for (int c = 0; c < eff_cols(); c++)
        if (!img_written[r * MAX_COLS + c])
          send_word(CMD_LOAD_IMAGE, coord_t'(r), coord_t'(c), rand_value());
  endtask

  task automatic random_traffic(input int n_words);
    int pick;
    int nr;
    int nc;
    int hi_r;
    int hi_c;
    coord_t r;
    coord_t c;
    nr   = eff_rows();
    nc   = eff_cols();
    hi_r = (nr + eff_ksize() > MAX_ROWS) ? MAX_ROWS - 1 : nr + eff_ksize() - 1;
    hi_c = (nc + eff_ksize() > MAX_COLS) ? MAX_COLS - 1 : nc + eff_ksize() - 1;
    for (int n = 0; n < n_words; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        r = ($urandom_range(0, 3) != 0) ? coord_t'($urandom_range(0, hi_r))
                                        : coord_t'($urandom_range(0, 63));
        c = ($urandom_range(0, 3) != 0) ? coord_t'($urandom_range(0, hi_c))
                                        : coord_t'($urandom_range(0, 63));
        send_word(CMD_REQUEST, r, c, value_t'($urandom_range(0, 65535)));
      end else if (pick < 80) begin
        if ($urandom_range(0, 7) != 0) begin
          r = coord_t'($urandom_range(0, nr - 1));
          c = coord_t'($urandom_range(0, nc - 1));
        end else begin
          r = coord_t'($urandom_range(0, 63));
          c = coord_t'($urandom_range(0, 63));
        end
        send_word(CMD_LOAD_IMAGE, r, c, rand_value());
      end else if (pick < 95) begin
        if ($urandom_range(0, 4) != 0) begin
          r = coord_t'($urandom_range(0, 7));
          c = coord_t'($urandom_range(0, 7));
        end else begin
          r = coord_t'($urandom_range(0, 63));
          c = coord_t'($urandom_range(0, 63));
        end
        send_word(CMD_LOAD_KERNEL, r, c, rand_value());
      end else begin
        send_word(CMD_UNUSED, coord_t'($urandom_range(0, 63)), coord_t'($urandom_range(0, 63)),
                  value_t'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic run_phase(input int rows_raw, input int cols_raw, input int k_raw,
                           input int n_words);
    wait_idle();
    set_idle_mode(idle_mode_t'(phases_run % 4));
    apply_setting(rows_raw, cols_raw, k_raw);
    fill_stores();
    random_traffic(n_words);
    phases_run++;
  endtask

  // reset values: 1x1 image, 3x3 kernel
  task automatic test_reset_defaults();
    set_idle_mode(IDLE_NONE);
    send_word(CMD_LOAD_KERNEL, 6'd0, 6'd0, 16'sh8000);
    send_word(CMD_LOAD_KERNEL, 6'd0, 6'd1, 16'sh7fff);
    send_word(CMD_LOAD_KERNEL, 6'd0, 6'd2, -16'sd1);
    send_word(CMD_LOAD_KERNEL, 6'd1, 6'd0, 16'sd1);
    send_word(CMD_LOAD_KERNEL, 6'd1, 6'd1, 16'sh8000);
    send_word(CMD_LOAD_KERNEL, 6'd1, 6'd2, 16'sd0);
    send_word(CMD_LOAD_KERNEL, 6'd2, 6'd0, 16'sd12345);
    send_word(CMD_LOAD_KERNEL, 6'd2, 6'd1, -16'sd12345);
    send_word(CMD_LOAD_KERNEL, 6'd2, 6'd2, 16'sh7fff);
    send_word(CMD_LOAD_IMAGE, 6'd0, 6'd0, 16'sh8000);
    // outside the configured image: stored, not read yet
    send_word(CMD_LOAD_IMAGE, 6'd63, 6'd63, 16'sh7fff);
    send_word(CMD_LOAD_IMAGE, 6'd0, 6'd63, 16'sh5555);
    // beyond the kernel store: dropped
    send_word(CMD_LOAD_KERNEL, 6'd0, 6'd7, 16'sd777);
    send_word(CMD_LOAD_KERNEL, 6'd7, 6'd0, -16'sd777);
    send_word(CMD_LOAD_KERNEL, 6'd63, 6'd63, 16'sh7fff);
    send_word(CMD_UNUSED, 6'd63, 6'd63, -16'sd1);
    send_word(CMD_REQUEST, 6'd0, 6'd0, 16'sd0);
    send_word(CMD_REQUEST, 6'd0, 6'd1, -16'sd1);
    send_word(CMD_REQUEST, 6'd1, 6'd0, 16'sd0);
    send_word(CMD_REQUEST, 6'd1, 6'd1, 16'sd0);
    send_word(CMD_REQUEST, 6'd2, 6'd2, 16'sd0);
    send_word(CMD_REQUEST, 6'd63, 6'd0, 16'sd0);
    send_word(CMD_REQUEST, 6'd63, 6'd63, 16'sd0);
    send_word(CMD_REQUEST, 6'd0, 6'd63, 16'sd0);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_SPARE, 32'hffff_ffff);
    run_phase(127, 2, 7, 15);
    run_phase(1, 64, 1, 15);
    run_phase(0, 0, 0, 15);
    run_phase(65, 3, 5, 15);
    run_phase(64, 2, 7, 15);
  endtask

  task automatic test_even_kernels();
    run_phase(6, 9, 2, 30);
    run_phase(16, 6, 4, 30);
    run_phase(10, 10, 6, 30);
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 6; p++)
      run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 7), 30);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin : pixel_check
    pixel_exp_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result word, sum", longint'(res_ch.sum), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (res_ch.sum !== want.sum)
          report_mismatch("sum", longint'(res_ch.sum), longint'(want.sum));
        if (res_ch.out_row !== want.out_row)
          report_mismatch("out_row", res_ch.out_row, want.out_row);
        if (res_ch.out_col !== want.out_col)
          report_mismatch("out_col", res_ch.out_col, want.out_col);
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rows_cfg       = 1;
    cols_cfg       = 1;
    ksize_cfg      = 3;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    words_sent     = 0;
    reg_writes     = 0;
    phases_run     = 0;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    item_ch.valid  <= 1'b0;
    item_ch.cmd    <= CMD_LOAD_KERNEL;
    item_ch.row    <= '0;
    item_ch.col    <= '0;
    item_ch.value  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_even_kernels();
    test_random_mix();

    wait_idle();
    $display("sent %0d words, checked %0d result words, %0d register writes, %0d settings",
             words_sent, pixels_seen, reg_writes, phases_run + 1);
    $display("settings spanned kernels 1 to 7, odd and even, and images from 1x1 to 64 rows");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cnv2d_pkg.sv
rtl/cnv2d_if.sv
rtl/cnv2d_ram.sv
rtl/conv2d_zero_padded.sv
tb/sv/tb_conv2d_zero_padded.sv
